// ===== hw/rtl/wrp_pkg.sv =====
// Shared types and constants for the weighted random action planner.
// No dependencies; every other file of the block imports this package.
package wrp_pkg;

  // Table geometry and field widths.
  localparam int ENTRY_SLOTS = 6;
  localparam int ENTRY_W     = 41;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 41;
  localparam int STOP_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int RAND_W      = 32;
  localparam int WEIGHT_W    = 8;
  localparam int MS_W        = 16;
  localparam int WSUM_W      = 11;
  localparam int DEN_W       = 17;
  localparam int ACT_W       = 3;
  localparam int STEP_BITS   = 4;

  // Bit positions inside one action entry.
  localparam int EN_BIT     = 0;
  localparam int WEIGHT_LSB = 1;
  localparam int MIN_LSB    = 9;
  localparam int MAX_LSB    = 25;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_FORWARD,
    REG_BACKWARD,
    REG_LEFT_TURN,
    REG_RIGHT_TURN,
    REG_LEFT_UTURN,
    REG_RIGHT_UTURN,
    REG_STOP_RANGE,
    REG_START_DELAY
  } reg_idx_e;

  // Action code for an empty plan.
  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;

  // Reset contents of the table.
  localparam logic [ENTRY_SLOTS-1:0][ENTRY_W-1:0] ENTRY_RESET = {
    41'd40265676821, 41'd40265676821, 41'd21810508831,
    41'd21810508831, 41'd26843699231, 41'd26843699251
  };
  localparam logic [STOP_W-1:0]  STOP_RESET  = 32'd524291000;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd3000;

  // Digest of the table, ready for the pipeline.
  typedef struct packed {
    logic                                ok;
    logic [ENTRY_SLOTS-1:0]              en;
    logic [ENTRY_SLOTS-1:0][WSUM_W-1:0]  cum;
    logic [WSUM_W-1:0]                   total;
    logic [ENTRY_SLOTS-1:0][MS_W-1:0]    run_min;
    logic [ENTRY_SLOTS-1:0][DEN_W-1:0]   run_den;
    logic [MS_W-1:0]                     stop_min;
    logic [DEN_W-1:0]                    stop_den;
  } cfg_sum_t;

  // Partial plan carried alongside the duration remainder.
  typedef struct packed {
    logic             err;
    logic [ACT_W-1:0] action;
    logic [MS_W-1:0]  run_min;
    logic [MS_W-1:0]  pause_ms;
  } plan_t;

endpackage

// ===== hw/rtl/weighted_random_action_planner_core.sv =====
// Weighted random action planner: top level with the configuration table.
// Depends on wrp_pkg, wrp_cfg_check, wrp_rem_pipe and wrp_select.
//
// Usage: each input word carries three random numbers. One result word per
// input word leaves on the output channel in the same order: a status bit,
// the chosen action and its run and pause durations, all zero but the
// status on an invalid table. Both channels use valid/ready.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while no
// word is in flight, which the user must ensure; the block does not enforce
// it. A write takes effect for words accepted afterwards. Each word passes
// nineteen registers: one intake register, eight stages of the ticket and
// pause remainder unit (four dividend bits each), one selection stage,
// eight stages of the duration remainder unit and the output register.
// Throughput is one word per cycle while the receiver is ready.
// When the receiver stalls, words close up behind the output register and
// the input stays ready until every stage is occupied; nothing is dropped.
// Reset clears all pipeline valids and loads the default action table.
module weighted_random_action_planner_core #(
  parameter int ACTION_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wrp_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [wrp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wrp_pkg::RAND_W-1:0]    pick_random_i,
  input  logic [wrp_pkg::RAND_W-1:0]    length_random_i,
  input  logic [wrp_pkg::RAND_W-1:0]    pause_random_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [wrp_pkg::ACT_W-1:0]     chosen_action_o,
  output logic [wrp_pkg::MS_W-1:0]      run_ms_o,
  output logic [wrp_pkg::MS_W-1:0]      pause_ms_o
);
  import wrp_pkg::*;

  localparam int PLAN_W = $bits(plan_t);

  logic [ENTRY_SLOTS-1:0][ENTRY_W-1:0] entry_q;
  logic [STOP_W-1:0]                   stop_range_q;
  logic [DELAY_W-1:0]                  start_delay_q;
  cfg_sum_t                            sum;

  // Configuration table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q       <= ENTRY_RESET;
      stop_range_q  <= STOP_RESET;
      start_delay_q <= DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i)) inside
        REG_FORWARD, REG_BACKWARD, REG_LEFT_TURN, REG_RIGHT_TURN,
        REG_LEFT_UTURN, REG_RIGHT_UTURN: begin
          entry_q[cfg_idx_i] <= cfg_wdata_i[ENTRY_W-1:0];
        end
        REG_STOP_RANGE: begin
          stop_range_q <= cfg_wdata_i[STOP_W-1:0];
        end
        REG_START_DELAY: begin
          start_delay_q <= cfg_wdata_i[DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  wrp_cfg_check #(
    .ACTION_COUNT (ACTION_COUNT)
  ) u_cfg_check (
    .clk_i         (clk_i),
    .entry_i       (entry_q),
    .stop_range_i  (stop_range_q),
    .start_delay_i (start_delay_q),
    .sum_o         (sum)
  );

  // Intake register: lets the registered table digest catch up with the table.
  logic              in_v_q;
  logic              in_adv;
  logic              div1_ready;
  logic [RAND_W-1:0] pick_q, length_q, pause_q;

  assign in_adv     = !in_v_q || div1_ready;
  assign in_ready_o = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_adv) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      pick_q   <= pick_random_i;
      length_q <= length_random_i;
      pause_q  <= pause_random_i;
    end
  end

  // Ticket (lane 0) and pause (lane 1) remainders.
  logic                       div1_valid, sel_ready;
  logic [1:0][DEN_W-1:0]      div1_rem;
  logic [RAND_W-1:0]          div1_length;

  wrp_rem_pipe #(
    .LANES     (2),
    .NUM_W     (RAND_W),
    .DEN_W     (DEN_W),
    .STEP_BITS (STEP_BITS),
    .SIDE_W    (RAND_W)
  ) u_div_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_v_q),
    .in_ready_o  (div1_ready),
    .in_num_i    ({pause_q, pick_q}),
    .in_den_i    ({sum.stop_den, DEN_W'(sum.total)}),
    .in_side_i   (length_q),
    .out_valid_o (div1_valid),
    .out_ready_i (sel_ready),
    .out_rem_o   (div1_rem),
    .out_side_o  (div1_length)
  );

  logic              sel_valid, div2_ready;
  plan_t             sel_plan;
  logic [RAND_W-1:0] sel_length;
  logic [DEN_W-1:0]  sel_run_den;

  wrp_select u_select (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sum_i           (sum),
    .in_valid_i      (div1_valid),
    .in_ready_o      (sel_ready),
    .ticket_i        (div1_rem[0]),
    .pause_rem_i     (div1_rem[1]),
    .length_random_i (div1_length),
    .out_valid_o     (sel_valid),
    .out_ready_i     (div2_ready),
    .plan_o          (sel_plan),
    .length_random_o (sel_length),
    .run_den_o       (sel_run_den)
  );

  // Run duration remainder.
  logic                  div2_valid, fin_ready;
  logic [0:0][DEN_W-1:0] div2_rem;
  logic [PLAN_W-1:0]     div2_side;
  plan_t                 div2_plan;

  wrp_rem_pipe #(
    .LANES     (1),
    .NUM_W     (RAND_W),
    .DEN_W     (DEN_W),
    .STEP_BITS (STEP_BITS),
    .SIDE_W    (PLAN_W)
  ) u_div_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid),
    .in_ready_o  (div2_ready),
    .in_num_i    (sel_length),
    .in_den_i    (sel_run_den),
    .in_side_i   (sel_plan),
    .out_valid_o (div2_valid),
    .out_ready_i (fin_ready),
    .out_rem_o   (div2_rem),
    .out_side_o  (div2_side)
  );

  assign div2_plan = plan_t'(div2_side);

  // Output register: offsets the duration and blanks an error plan.
  logic             out_v_q;
  logic             status_q;
  logic [ACT_W-1:0] action_q;
  logic [MS_W-1:0]  run_q, pause_ms_q;

  assign fin_ready = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin_ready) begin
      out_v_q <= div2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready && div2_valid) begin
      status_q   <= div2_plan.err;
      action_q   <= div2_plan.err ? ACT_NONE : div2_plan.action;
      run_q      <= div2_plan.err ? '0 : div2_plan.run_min + div2_rem[0][MS_W-1:0];
      pause_ms_q <= div2_plan.err ? '0 : div2_plan.pause_ms;
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = status_q;
  assign chosen_action_o = action_q;
  assign run_ms_o        = run_q;
  assign pause_ms_o      = pause_ms_q;

endmodule

// ===== hw/rtl/wrp_cfg_check.sv =====
// Validates the action table and precomputes weight sums and range spans.
// Depends on wrp_pkg.
module wrp_cfg_check #(
  parameter int ACTION_COUNT = 6
) (
  input  logic                                                  clk_i,
  input  logic [wrp_pkg::ENTRY_SLOTS-1:0][wrp_pkg::ENTRY_W-1:0] entry_i,
  input  logic [wrp_pkg::STOP_W-1:0]                            stop_range_i,
  input  logic [wrp_pkg::DELAY_W-1:0]                           start_delay_i,
  output wrp_pkg::cfg_sum_t                                     sum_o
);
  import wrp_pkg::*;

  cfg_sum_t sum_d, sum_q;

  // Walk the entries: enable mask, running weight sums and the table checks.
  always_comb begin
    logic                en;
    logic [WEIGHT_W-1:0] w;
    logic [MS_W-1:0]     mn;
    logic [MS_W-1:0]     mx;
    logic [WSUM_W-1:0]   acc;
    logic                bad;
    logic [MS_W-1:0]     smin;
    logic [MS_W-1:0]     smax;
    acc   = '0;
    bad   = 1'b0;
    sum_d = '0;
    for (int i = 0; i < ENTRY_SLOTS; i++) begin
      en = entry_i[i][EN_BIT] && (i < ACTION_COUNT);
      w  = entry_i[i][WEIGHT_LSB +: WEIGHT_W];
      mn = entry_i[i][MIN_LSB +: MS_W];
      mx = entry_i[i][MAX_LSB +: MS_W];
      if (en && (w == '0 || mn == '0 || mn > mx)) begin
        bad = 1'b1;
      end
      if (en) begin
        acc = acc + WSUM_W'(w);
      end
      sum_d.en[i]      = en;
      sum_d.cum[i]     = acc;
      sum_d.run_min[i] = mn;
      sum_d.run_den[i] = {1'b0, mx} - {1'b0, mn} + DEN_W'(1);
    end
    smin           = stop_range_i[MS_W-1:0];
    smax           = stop_range_i[STOP_W-1:MS_W];
    sum_d.total    = acc;
    sum_d.stop_min = smin;
    sum_d.stop_den = {1'b0, smax} - {1'b0, smin} + DEN_W'(1);
    sum_d.ok       = !bad && (acc != '0) && (smin != '0) &&
                     (start_delay_i != '0) && (smin <= smax);
  end

  // The digest follows the table in the next cycle.
  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

// ===== hw/rtl/wrp_rem_pipe.sv =====
// Pipelined restoring remainder unit, STEP_BITS dividend bits per stage,
// with a side word carried along. Depends on wrp_pkg only by convention.
module wrp_rem_pipe #(
  parameter int LANES     = 1,
  parameter int NUM_W     = 32,
  parameter int DEN_W     = 17,
  parameter int STEP_BITS = 4,
  parameter int SIDE_W    = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [LANES-1:0][NUM_W-1:0]       in_num_i,
  input  logic [LANES-1:0][DEN_W-1:0]       in_den_i,
  input  logic [SIDE_W-1:0]                 in_side_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [LANES-1:0][DEN_W-1:0]       out_rem_o,
  output logic [SIDE_W-1:0]                 out_side_o
);
  import wrp_pkg::*;

  localparam int STAGES = NUM_W / STEP_BITS;

  logic [STAGES-1:0]              valid_q;
  logic [STAGES:0]                adv;
  logic [LANES-1:0][DEN_W-1:0]    rem_q  [STAGES];
  logic [LANES-1:0][NUM_W-1:0]    num_q  [STAGES];
  logic [LANES-1:0][DEN_W-1:0]    den_q  [STAGES];
  logic [SIDE_W-1:0]              side_q [STAGES];

  // STEP_BITS shift-compare-subtract steps of long division.
  function automatic logic [DEN_W-1:0] rem_step(input logic [DEN_W-1:0]     rem,
                                                input logic [STEP_BITS-1:0] bits,
                                                input logic [DEN_W-1:0]     den);
    logic [DEN_W:0]   wide;
    logic [DEN_W-1:0] r;
    r = rem;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      wide = {r, bits[k]};
      if (wide >= {1'b0, den}) begin
        wide = wide - {1'b0, den};
      end
      r = wide[DEN_W-1:0];
    end
    return r;
  endfunction

  // A stage moves when it is empty or the stage after it moves.
  assign adv[STAGES] = out_ready_i;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                           src_valid;
    logic [LANES-1:0][DEN_W-1:0]    src_rem;
    logic [LANES-1:0][NUM_W-1:0]    src_num;
    logic [LANES-1:0][DEN_W-1:0]    src_den;
    logic [SIDE_W-1:0]              src_side;

    if (s == 0) begin : g_first
      assign src_valid = in_valid_i;
      assign src_rem   = '0;
      assign src_num   = in_num_i;
      assign src_den   = in_den_i;
      assign src_side  = in_side_i;
    end else begin : g_next
      assign src_valid = valid_q[s-1];
      assign src_rem   = rem_q[s-1];
      assign src_num   = num_q[s-1];
      assign src_den   = den_q[s-1];
      assign src_side  = side_q[s-1];
    end

    assign adv[s] = !valid_q[s] || adv[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv[s]) begin
        valid_q[s] <= src_valid;
      end
    end

    // Each lane consumes the top STEP_BITS of its remaining dividend.
    always_ff @(posedge clk_i) begin
      if (adv[s] && src_valid) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= rem_step(src_rem[l], src_num[l][NUM_W-1 -: STEP_BITS],
                                  src_den[l]);
          num_q[s][l] <= src_num[l] << STEP_BITS;
        end
        den_q[s]  <= src_den;
        side_q[s] <= src_side;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[STAGES-1];
  assign out_rem_o   = rem_q[STAGES-1];
  assign out_side_o  = side_q[STAGES-1];

endmodule

// ===== hw/rtl/wrp_select.sv =====
// Roulette selection from the reduced ticket and completion of the pause.
// Depends on wrp_pkg.
module wrp_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrp_pkg::cfg_sum_t             sum_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wrp_pkg::DEN_W-1:0]     ticket_i,
  input  logic [wrp_pkg::DEN_W-1:0]     pause_rem_i,
  input  logic [wrp_pkg::RAND_W-1:0]    length_random_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wrp_pkg::plan_t                plan_o,
  output logic [wrp_pkg::RAND_W-1:0]    length_random_o,
  output logic [wrp_pkg::DEN_W-1:0]     run_den_o
);
  import wrp_pkg::*;

  logic                 valid_q;
  logic                 adv;
  plan_t                plan_d, plan_q;
  logic [DEN_W-1:0]     run_den_d, run_den_q;
  logic [RAND_W-1:0]    length_q;

  // First enabled action whose cumulative weight lies above the ticket.
  always_comb begin
    logic found;
    found     = 1'b0;
    plan_d    = '0;
    run_den_d = sum_i.run_den[0];
    plan_d.action = ACT_NONE;
    for (int i = 0; i < ENTRY_SLOTS; i++) begin
      if (!found && sum_i.en[i] && (ticket_i < DEN_W'(sum_i.cum[i]))) begin
        found          = 1'b1;
        plan_d.action  = ACT_W'(i + 1);
        plan_d.run_min = sum_i.run_min[i];
        run_den_d      = sum_i.run_den[i];
      end
    end
    plan_d.err      = !sum_i.ok || !found;
    plan_d.pause_ms = sum_i.stop_min + pause_rem_i[MS_W-1:0];
  end

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      plan_q    <= plan_d;
      run_den_q <= run_den_d;
      length_q  <= length_random_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign plan_o          = plan_q;
  assign run_den_o       = run_den_q;
  assign length_random_o = length_q;

endmodule

// ===== tb/wrp_plan_checker.sv =====
`timescale 1ns / 100ps
// Plan checker for the weighted random action planner. It watches both word
// channels and the register port, predicts each plan and compares it.
// Depends on wrp_pkg for table geometry, register indexes and reset values.
module wrp_plan_checker #(
  parameter int ACTION_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wrp_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [wrp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [wrp_pkg::RAND_W-1:0]    pick_random_i,
  input  logic [wrp_pkg::RAND_W-1:0]    length_random_i,
  input  logic [wrp_pkg::RAND_W-1:0]    pause_random_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          status_i,
  input  logic [wrp_pkg::ACT_W-1:0]     chosen_action_i,
  input  logic [wrp_pkg::MS_W-1:0]      run_ms_i,
  input  logic [wrp_pkg::MS_W-1:0]      pause_ms_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);
  import wrp_pkg::*;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic             status;
    logic [ACT_W-1:0] action;
    logic [MS_W-1:0]  run_ms;
    logic [MS_W-1:0]  pause_ms;
  } plan_s;

  // Local copy of the action table and the timing registers.
  logic [ENTRY_W-1:0] entry_tbl [ENTRY_SLOTS];
  logic [STOP_W-1:0]  stop_rng;
  logic [DELAY_W-1:0] delay_ms;

  // Plans still owed by the block, oldest first.
  plan_s       plan_q [$];
  int unsigned fail_cnt;

  // Validates the table, spins the roulette wheel and draws both durations.
  function automatic plan_s predict_plan(input logic [RAND_W-1:0] pick,
                                         input logic [RAND_W-1:0] run_rnd,
                                         input logic [RAND_W-1:0] pause_rnd);
    plan_s       res;
    logic        tbl_ok;
    int unsigned slots;
    int unsigned total;
    int unsigned ticket;
    int unsigned chosen;
    int unsigned wgt;
    int unsigned lo;
    int unsigned hi;
    int unsigned p_lo;
    int unsigned p_hi;
    res        = '0;
    res.status = STATUS_ERR;
    res.action = ACT_NONE;
    slots  = (ACTION_COUNT > ENTRY_SLOTS) ? ENTRY_SLOTS : ACTION_COUNT;
    p_lo   = 32'(stop_rng[15:0]);
    p_hi   = 32'(stop_rng[31:16]);
    tbl_ok = (p_lo != 0) && (delay_ms != 0) && (p_lo <= p_hi);
    total  = 0;
    // Only enabled entries are checked and summed.
    for (int i = 0; i < slots; i++) begin
      if (entry_tbl[i][EN_BIT]) begin
        wgt = 32'(entry_tbl[i][WEIGHT_LSB +: WEIGHT_W]);
        lo  = 32'(entry_tbl[i][MIN_LSB +: MS_W]);
        hi  = 32'(entry_tbl[i][MAX_LSB +: MS_W]);
        if (wgt == 0 || lo == 0 || lo > hi) tbl_ok = 1'b0;
        else total += wgt;
      end
    end
    if (!tbl_ok || total == 0) return res;
    // Walk the wheel in action order until the ticket lands in a weight.
    ticket = pick % total;
    chosen = 0;
    for (int i = 0; i < slots; i++) begin
      if (entry_tbl[i][EN_BIT] && chosen == 0) begin
        wgt = 32'(entry_tbl[i][WEIGHT_LSB +: WEIGHT_W]);
        if (ticket < wgt) chosen = i + 1;
        else ticket -= wgt;
      end
    end
    if (chosen == 0) return res;
    lo = 32'(entry_tbl[chosen-1][MIN_LSB +: MS_W]);
    hi = 32'(entry_tbl[chosen-1][MAX_LSB +: MS_W]);
    res.status   = STATUS_OK;
    res.action   = ACT_W'(chosen);
    res.run_ms   = MS_W'(lo + run_rnd % (hi - lo + 1));
    res.pause_ms = MS_W'(p_lo + pause_rnd % (p_hi - p_lo + 1));
    return res;
  endfunction

  // Track register writes, predict accepted words and check returned ones.
  always @(posedge clk_i or negedge rst_ni) begin
    plan_s want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_SLOTS; i++) entry_tbl[i] = ENTRY_RESET[i];
      stop_rng = STOP_RESET;
      delay_ms = DELAY_RESET;
      plan_q.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_FORWARD, REG_BACKWARD, REG_LEFT_TURN, REG_RIGHT_TURN,
          REG_LEFT_UTURN, REG_RIGHT_UTURN: begin
            entry_tbl[cfg_idx_i] = cfg_wdata_i[ENTRY_W-1:0];
          end
          REG_STOP_RANGE: begin
            stop_rng = cfg_wdata_i[STOP_W-1:0];
          end
          REG_START_DELAY: begin
            delay_ms = cfg_wdata_i[DELAY_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        plan_q.push_back(predict_plan(pick_random_i, length_random_i, pause_random_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (plan_q.size() == 0) begin
          $error("plan word returned with none outstanding");
          fail_cnt++;
        end else begin
          want = plan_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_cnt++;
          end
          if (chosen_action_i !== want.action) begin
            $error("chosen_action: expected %0d, got %0d", want.action, chosen_action_i);
            fail_cnt++;
          end
          if (run_ms_i !== want.run_ms) begin
            $error("run_ms: expected %0d, got %0d", want.run_ms, run_ms_i);
            fail_cnt++;
          end
          if (pause_ms_i !== want.pause_ms) begin
            $error("pause_ms: expected %0d, got %0d", want.pause_ms, pause_ms_i);
            fail_cnt++;
          end
        end
      end
    end
    pending_o    <= plan_q.size();
    fail_count_o <= fail_cnt;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the planner testbench: clock, reset, table programming and word
// traffic with random gaps. Depends on wrp_pkg, the planner core and wrp_plan_checker.
module tb;
  import wrp_pkg::*;

  localparam int PIPE_LATENCY = 19;

  // Ways of breaking an otherwise sound table.
  typedef enum int {
    FAULT_NONE,
    FAULT_PAUSE_ZERO,
    FAULT_DELAY_ZERO,
    FAULT_PAUSE_ORDER,
    FAULT_WEIGHT_ZERO,
    FAULT_RUN_ZERO,
    FAULT_RUN_ORDER,
    FAULT_NO_ACTION
  } fault_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [RAND_W-1:0] pick_random_i;
  logic [RAND_W-1:0] length_random_i;
  logic [RAND_W-1:0] pause_random_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              status_o;
  logic [ACT_W-1:0]  chosen_action_o;
  logic [MS_W-1:0]   run_ms_o;
  logic [MS_W-1:0]   pause_ms_o;
  int unsigned       pending;
  int unsigned       fail_count;

  // Table image written to the block by program_table.
  logic [CFG_W-1:0] cfg_img [8];
  // When set, neither side leaves gaps.
  logic             calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  weighted_random_action_planner_core #(.ACTION_COUNT(6)) dut (.*);

  wrp_plan_checker #(.ACTION_COUNT(6)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .pick_random_i   (pick_random_i),
    .length_random_i (length_random_i),
    .pause_random_i  (pause_random_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .chosen_action_i (chosen_action_o),
    .run_ms_i        (run_ms_o),
    .pause_ms_i      (pause_ms_o),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] make_entry(input logic en, input logic [7:0] wgt,
                                                  input logic [15:0] lo,
                                                  input logic [15:0] hi);
    return {hi, lo, wgt, en};
  endfunction

  // Random inclusive range {max, min} with a sound ordering.
  function automatic logic [31:0] rand_span();
    logic [15:0] lo;
    logic [15:0] hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = 16'd1;
        hi = 16'hFFFF;
      end
      1: begin
        lo = 16'($urandom_range(1, 65535));
        hi = lo;
      end
      2: begin
        lo = 16'hFFFF;
        hi = 16'hFFFF;
      end
      3: begin
        lo = 16'($urandom_range(1, 40));
        hi = 16'(lo + $urandom_range(0, 20));
      end
      default: begin
        lo = 16'($urandom_range(1, 65535));
        hi = 16'($urandom_range(lo, 65535));
      end
    endcase
    return {hi, lo};
  endfunction

  function automatic logic [7:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_plan(input logic [RAND_W-1:0] pick, input logic [RAND_W-1:0] run_rnd,
                           input logic [RAND_W-1:0] pause_rnd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    pick_random_i   <= pick;
    length_random_i <= run_rnd;
    pause_random_i  <= pause_rnd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every plan has come back and the pipeline has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (PIPE_LATENCY + 6) @(posedge clk_i);
  endtask

  // Writes all eight registers; spare upper bits of the narrow ones carry junk.
  task automatic program_table();
    logic [CFG_W-1:0] data;
    for (int i = 0; i < 8; i++) begin
      data = cfg_img[i];
      if (i == REG_STOP_RANGE) data[CFG_W-1:STOP_W] = (CFG_W-STOP_W)'($urandom);
      if (i == REG_START_DELAY) begin
        data[CFG_W-1:DELAY_W] = (CFG_W-DELAY_W)'({$urandom, $urandom});
      end
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_idx_e'(i);
      cfg_wdata_i <= data;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic default_table();
    for (int i = 0; i < ENTRY_SLOTS; i++) cfg_img[i] = ENTRY_RESET[i];
    cfg_img[REG_STOP_RANGE]  = CFG_W'(STOP_RESET);
    cfg_img[REG_START_DELAY] = CFG_W'(DELAY_RESET);
  endtask

  task automatic inject_fault(input fault_e f);
    int          slot;
    int unsigned a;
    slot = $urandom_range(0, ENTRY_SLOTS - 1);
    case (f)
      FAULT_PAUSE_ZERO: cfg_img[REG_STOP_RANGE][15:0] = '0;
      FAULT_DELAY_ZERO: cfg_img[REG_START_DELAY] = '0;
      FAULT_PAUSE_ORDER: begin
        a = $urandom_range(2, 65535);
        cfg_img[REG_STOP_RANGE] = CFG_W'({16'($urandom_range(1, a - 1)), 16'(a)});
      end
      FAULT_WEIGHT_ZERO: begin
        cfg_img[slot][EN_BIT] = 1'b1;
        cfg_img[slot][WEIGHT_LSB +: WEIGHT_W] = '0;
      end
      FAULT_RUN_ZERO: begin
        cfg_img[slot][EN_BIT] = 1'b1;
        cfg_img[slot][MIN_LSB +: MS_W] = '0;
      end
      FAULT_RUN_ORDER: begin
        a = $urandom_range(2, 65535);
        cfg_img[slot] = make_entry(1'b1, rand_weight(), 16'(a),
                                   16'($urandom_range(1, a - 1)));
      end
      FAULT_NO_ACTION: begin
        for (int i = 0; i < ENTRY_SLOTS; i++) cfg_img[i][EN_BIT] = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Mostly sound tables with the odd disabled entry full of junk.
  task automatic random_table();
    logic [31:0] span;
    int          enabled;
    enabled = 0;
    for (int i = 0; i < ENTRY_SLOTS; i++) begin
      if ($urandom_range(0, 9) != 0) begin
        span = rand_span();
        cfg_img[i] = make_entry(1'b1, rand_weight(), span[15:0], span[31:16]);
        enabled++;
      end else begin
        cfg_img[i] = CFG_W'({$urandom, $urandom});
        cfg_img[i][EN_BIT] = 1'b0;
      end
    end
    if (enabled == 0) begin
      span = rand_span();
      cfg_img[$urandom_range(0, ENTRY_SLOTS - 1)] =
        make_entry(1'b1, rand_weight(), span[15:0], span[31:16]);
    end
    cfg_img[REG_STOP_RANGE] = CFG_W'(rand_span());
    cfg_img[REG_START_DELAY] = ($urandom_range(0, 9) == 0) ? CFG_W'(16'hFFFF)
                                                           : CFG_W'($urandom_range(1, 65535));
    if ($urandom_range(0, 6) == 0) inject_fault(fault_e'($urandom_range(1, 7)));
  endtask

  // Receiver: bursts of readiness broken by random stalls.
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat (calm ? 40 : $urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned boundary_picks [13];
    boundary_picks = '{0, 24, 25, 39, 40, 54, 55, 69, 70, 79, 80, 89, 32'hFFFFFFFF};
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_FORWARD;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    pick_random_i   <= '0;
    length_random_i <= '0;
    pause_random_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset table: every action boundary, duration random words all zeros or all ones.
    for (int k = 0; k < 13; k++) begin
      send_plan(boundary_picks[k], (k % 2) ? '1 : '0, (k % 2) ? '0 : '1);
    end

    // Each kind of invalid table once.
    for (int f = FAULT_PAUSE_ZERO; f <= FAULT_NO_ACTION; f++) begin
      settle();
      default_table();
      inject_fault(fault_e'(f));
      program_table();
      send_plan($urandom, $urandom, $urandom);
    end

    // Disabled entries hold junk and must be skipped; only the last action is live.
    settle();
    default_table();
    cfg_img[0] = make_entry(1'b0, 8'd0, 16'd0, 16'd0);
    cfg_img[1] = make_entry(1'b0, 8'd255, 16'hFFFF, 16'd1);
    cfg_img[2] = make_entry(1'b0, 8'd7, 16'd0, 16'hFFFF);
    cfg_img[3] = CFG_W'({$urandom, $urandom}) & ~CFG_W'(1);
    cfg_img[4] = make_entry(1'b0, 8'd0, 16'd9, 16'd3);
    cfg_img[5] = make_entry(1'b1, 8'd255, 16'd1, 16'hFFFF);
    cfg_img[REG_STOP_RANGE]  = CFG_W'({16'hFFFF, 16'd1});
    cfg_img[REG_START_DELAY] = CFG_W'(16'hFFFF);
    program_table();
    send_plan('1, '1, '1);
    send_plan('0, 32'd65534, 32'd65534);

    // Heaviest wheel with degenerate ranges at the top of the scale.
    settle();
    for (int i = 0; i < ENTRY_SLOTS; i++) cfg_img[i] = make_entry(1'b1, 8'd255, '1, '1);
    cfg_img[REG_STOP_RANGE]  = CFG_W'({16'hFFFF, 16'hFFFF});
    cfg_img[REG_START_DELAY] = CFG_W'(16'd1);
    program_table();
    send_plan('1, '1, '0);
    send_plan(32'd1529, '0, '1);

    // Random tables, fifty words each.
    for (int ph = 0; ph < 25; ph++) begin
      settle();
      random_table();
      program_table();
      calm = ($urandom_range(0, 3) == 0);
      repeat (50) send_plan($urandom, $urandom, $urandom);
    end

    settle();
    if (fail_count == 0) begin
      $display("weighted_random_action_planner_core: match");
    end else begin
      $display("weighted_random_action_planner_core: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("weighted_random_action_planner_core: mismatch");
    $finish;
  end

endmodule
